### design/wma_pkg.sv
// ----------------------------------------------------------------------------
// wma_pkg
// Shared types and constants of the weighted moving average block.
// ----------------------------------------------------------------------------
package wma_pkg;

    // fixed field widths
    localparam int SAMPLE_W     = 16;
    localparam int WEIGHT_W     = 8;
    localparam int WEIGHT_SLOTS = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int TAP_CNT_W    = 4;

    // eight taps of 16x8 products fit in 27 signed bits, magnitude in 26
    localparam int ACC_W  = 27;
    localparam int MAG_W  = 26;
    localparam int WSUM_W = 11;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [WEIGHT_W-1:0]        t_weight;
    typedef logic [TAP_CNT_W-1:0]       t_tap_cnt;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    // register indexes
    typedef enum logic {
        REG_TAP_COUNT   = 1'b0,
        REG_TAP_WEIGHTS = 1'b1
    } t_cfg_idx;

    localparam t_tap_cnt TAP_COUNT_RESET  = 4'd8;
    localparam t_cfg_data WEIGHTS_RESET   = 64'h0101_0101_0101_0101;

    // partial sums handed from cell to cell
    typedef struct packed {
        logic                     tok;
        logic signed [ACC_W-1:0]  acc;
        logic [WSUM_W-1:0]        wsum;
    } t_link;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DIV,
        S_DONE
    } t_state;

endpackage

### design/wma_if.sv
// ----------------------------------------------------------------------------
// wma_if
// Valid/ready channels of the weighted moving average block.
// ----------------------------------------------------------------------------
interface wma_sample_if
    import wma_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wma_result_if
    import wma_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample average;
    logic    zero_weight_sum;

    modport source (output valid, output average, output zero_weight_sum, input ready);
    modport sink   (input valid, input average, input zero_weight_sum, output ready);
endinterface

interface wma_cfg_if
    import wma_pkg::*;
;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/weighted_moving_average.sv
// Flow: a sample transaction starts a token that walks the tap chain, where
//   TAPS = min(MAX_TAPS, 8); the 26-step divider then runs on the weighted sum
//   and the result is registered at the output.
// One sample is in flight at a time; a zero weight sum skips the divider.
// Reset: synchronous active low; history cleared, tap_count min(MAX_TAPS, 8), all weights 1.
// ----------------------------------------------------------------------------
// weighted_moving_average
// Weighted moving average over a chain of tap cells with a serial divider.
// ----------------------------------------------------------------------------
module weighted_moving_average
    import wma_pkg::*;
#(
    parameter int MAX_TAPS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wma_cfg_if.sink       i_cfg,
    wma_sample_if.sink    i_in,
    wma_result_if.source  o_out
);

    localparam int TAP_LIM = (MAX_TAPS < WEIGHT_SLOTS) ? MAX_TAPS : WEIGHT_SLOTS;

    t_state    r_state;
    t_state    n_state;
    t_tap_cnt  r_tap_count;
    t_cfg_data r_weights;
    logic      r_start;
    logic      r_neg;
    t_sample   r_res_avg;
    logic      r_res_zero;
    logic      r_out_valid;
    t_sample   r_out_avg;
    logic      r_out_zero;

    logic      in_acc;
    logic      slot_free;
    logic      div_start;
    logic      div_done;
    logic [MAG_W-1:0] div_quo;
    logic [MAG_W-1:0] mag;
    logic [ACC_W-1:0] acc_neg;
    t_tap_cnt  cfg_taps;

    t_sample   hist [0:MAX_TAPS];
    t_link     link [0:MAX_TAPS];

    assign in_acc    = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;

    // configuration registers, tap count clamped into range
    assign i_cfg.ready = 1'b1;
    always_comb begin
        cfg_taps = i_cfg.data[TAP_CNT_W-1:0];
        if (cfg_taps == '0) begin
            cfg_taps = t_tap_cnt'(1);
        end else if (cfg_taps > t_tap_cnt'(TAP_LIM)) begin
            cfg_taps = t_tap_cnt'(TAP_LIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= (TAP_COUNT_RESET > t_tap_cnt'(TAP_LIM)) ?
                           t_tap_cnt'(TAP_LIM) : TAP_COUNT_RESET;
            r_weights   <= WEIGHTS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_TAP_COUNT:   r_tap_count <= cfg_taps;
                REG_TAP_WEIGHTS: r_weights   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // chain of tap cells
    assign hist[0] = i_in.sample;
    assign link[0] = '{tok: r_start, acc: '0, wsum: '0};

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        t_weight weight;
        logic    active;
        if (k < TAP_LIM) begin : g_on
            assign weight = r_weights[WEIGHT_W*k +: WEIGHT_W];
            assign active = t_tap_cnt'(k) < r_tap_count;
        end else begin : g_off
            assign weight = '0;
            assign active = 1'b0;
        end
        wma_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (in_acc),
            .i_hist   (hist[k]),
            .i_weight (weight),
            .i_active (active),
            .i_link   (link[k]),
            .o_hist   (hist[k+1]),
            .o_link   (link[k+1])
        );
    end

    // magnitude of the weighted sum for the divider
    assign acc_neg = -link[TAP_LIM].acc;
    assign mag     = link[TAP_LIM].acc[ACC_W-1] ? acc_neg[MAG_W-1:0]
                                                : link[TAP_LIM].acc[MAG_W-1:0];

    wma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag),
        .i_divisor  (link[TAP_LIM].wsum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= in_acc;
        end
    end

    // next state and divider start
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_MAC;
            end
            S_MAC: begin
                if (link[TAP_LIM].tok) begin
                    if (link[TAP_LIM].wsum == '0) begin
                        n_state = S_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // pending result
    always_ff @(posedge i_clk) begin
        if (r_state == S_MAC && link[TAP_LIM].tok) begin
            r_neg      <= link[TAP_LIM].acc[ACC_W-1];
            r_res_avg  <= '0;
            r_res_zero <= (link[TAP_LIM].wsum == '0);
        end else if (r_state == S_DIV && div_done) begin
            r_res_avg  <= r_neg ? -div_quo[SAMPLE_W-1:0] : div_quo[SAMPLE_W-1:0];
            r_res_zero <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_DONE && slot_free) begin
            r_out_avg  <= r_res_avg;
            r_out_zero <= r_res_zero;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.average         = r_out_avg;
    assign o_out.zero_weight_sum = r_out_zero;

endmodule

### design/wma_cell.sv
// ----------------------------------------------------------------------------
// wma_cell
// One tap: holds a history entry and adds its weighted product to the
// partial sum passing through.
// ----------------------------------------------------------------------------
module wma_cell
    import wma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  t_sample i_hist,
    input  t_weight i_weight,
    input  logic    i_active,
    input  t_link   i_link,
    output t_sample o_hist,
    output t_link   o_link
);

    t_sample r_hist;
    t_link   r_link;
    t_link   n_link;

    logic signed [SAMPLE_W+WEIGHT_W:0] prod;

    // history entry, shifted from the neighbour on each new sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_shift) begin
            r_hist <= i_hist;
        end
    end

    // weighted product of this tap
    assign prod = r_hist * $signed({1'b0, i_weight});

    always_comb begin
        n_link     = i_link;
        if (i_active) begin
            n_link.acc  = i_link.acc + ACC_W'(prod);
            n_link.wsum = i_link.wsum + WSUM_W'(i_weight);
        end
    end

    // partial sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
        end else begin
            r_link.tok <= n_link.tok;
        end
        r_link.acc  <= n_link.acc;
        r_link.wsum <= n_link.wsum;
    end

    assign o_hist = r_hist;
    assign o_link = r_link;

endmodule

### design/wma_div.sv
// ----------------------------------------------------------------------------
// wma_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module wma_div
    import wma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_dividend,
    input  logic [WSUM_W-1:0] i_divisor,
    output logic              o_done,
    output logic [MAG_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WSUM_W-1:0] r_rem;
    logic [WSUM_W-1:0] r_div;
    logic [MAG_W-1:0]  r_quo;

    logic [WSUM_W:0]   rem_sh;
    logic [WSUM_W:0]   diff;
    logic              q_bit;

    // trial subtraction
    assign rem_sh = {r_rem, r_quo[MAG_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign q_bit  = !diff[WSUM_W];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### design/wma_check.sv
// ----------------------------------------------------------------------------
// wma_check
// Port-level checks of the weighted moving average block.
// ----------------------------------------------------------------------------
module wma_check
    import wma_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_out_average,
    input logic    i_out_zero
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_average)
                                        && $stable(i_out_zero))
        else $error("result changed while stalled");

    // zero weight sum gives a zero average
    a_zero_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_zero |-> i_out_average == '0)
        else $error("nonzero average with zero weight sum");

    // one sample in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while another is in flight");

    // ready for a sample straight after reset
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");

endmodule

bind weighted_moving_average wma_check u_wma_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_average (o_out.average),
    .i_out_zero    (o_out.zero_weight_sum)
);

### sim/wma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_checker
// Watches the register, sample and result channels of the weighted moving
// average block. It keeps its own tap history and register copies, predicts
// one average per sample transaction and compares each result transaction
// against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module wma_checker
    import wma_pkg::*;
#(
    parameter int MAX_TAPS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wma_cfg_if    i_cfg,
    wma_sample_if i_in,
    wma_result_if i_out,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_results,
    output int    o_zero_sums
);

    localparam int TAP_LIMIT = (MAX_TAPS < WEIGHT_SLOTS) ? MAX_TAPS : WEIGHT_SLOTS;

    typedef struct packed {
        t_sample average;
        logic    zero_weight_sum;
    } t_avg_result;

    t_sample     history [MAX_TAPS];
    int unsigned active_taps;
    t_cfg_data   weights_q;
    t_avg_result pending_avgs [$];

    // tap count written out of range is pulled back into 1..limit
    function automatic int unsigned clamp_taps(input t_tap_cnt value);
        if (value < 1) return 1;
        if (value > TAP_LIMIT) return TAP_LIMIT;
        return value;
    endfunction

    always @(posedge i_clk) begin : monitor
        longint      acc;
        longint      wsum;
        t_weight     w;
        t_avg_result avg_exp;

        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) history[i] = '0;
            active_taps  = clamp_taps(TAP_COUNT_RESET);
            weights_q    = WEIGHTS_RESET;
            pending_avgs.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_results    = 0;
            o_zero_sums  = 0;
        end else begin
            // register write transaction
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_TAP_COUNT:   active_taps = clamp_taps(i_cfg.data[TAP_CNT_W-1:0]);
                    REG_TAP_WEIGHTS: weights_q = i_cfg.data;
                    default: ;
                endcase
            end

            // result transaction against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                o_results++;
                if (pending_avgs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got average %0d flag %0b",
                             $time, i_out.average, i_out.zero_weight_sum);
                    o_fail_count++;
                end else begin
                    avg_exp = pending_avgs.pop_front();
                    if (i_out.average !== avg_exp.average) begin
                        $display("%0t: average mismatch, expected %0d, got %0d",
                                 $time, avg_exp.average, i_out.average);
                        o_fail_count++;
                    end
                    if (i_out.zero_weight_sum !== avg_exp.zero_weight_sum) begin
                        $display("%0t: zero_weight_sum mismatch, expected %0b, got %0b",
                                 $time, avg_exp.zero_weight_sum, i_out.zero_weight_sum);
                        o_fail_count++;
                    end
                end
            end

            // sample transaction: shift the whole line, then weight the active taps
            if (i_in.valid && i_in.ready) begin
                for (int i = MAX_TAPS - 1; i > 0; i--) history[i] = history[i-1];
                history[0] = i_in.sample;
                acc  = 0;
                wsum = 0;
                for (int i = 0; i < TAP_LIMIT; i++) begin
                    if (i < active_taps) begin
                        w    = weights_q[WEIGHT_W*i +: WEIGHT_W];
                        acc  += longint'(history[i]) * longint'(w);
                        wsum += longint'(w);
                    end
                end
                // zero weight sum gives zero and raises the flag
                if (wsum == 0) begin
                    avg_exp.average         = '0;
                    avg_exp.zero_weight_sum = 1'b1;
                    o_zero_sums++;
                end else begin
                    avg_exp.average         = t_sample'(acc / wsum);
                    avg_exp.zero_weight_sum = 1'b0;
                end
                pending_avgs.push_back(avg_exp);
            end

            o_pending = pending_avgs.size();
        end
    end

endmodule

### sim/weighted_moving_average_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_moving_average_tb
// Drives the weighted moving average block with directed corner samples and
// register settings, then with random phases of settings and samples, while
// both sample sender and result receiver stall at random. The checker beside
// the block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module weighted_moving_average_tb;
    import wma_pkg::*;

    localparam int MAX_TAPS     = 8;
    localparam int RANDOM_ITEMS = 1350;
    localparam int IDLE_PCT     = 12;
    localparam int CALM_PHASE   = 3;
    localparam int CALM_LEN     = 200;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   cycle_count = 0;
    int   sent        = 0;
    int   settings    = 0;
    int   fail_count;
    int   pending;
    int   results;
    int   zero_sums;

    wma_cfg_if    cfg_ch ();
    wma_sample_if smp_ch ();
    wma_result_if res_ch ();

    weighted_moving_average #(
        .MAX_TAPS (MAX_TAPS)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (smp_ch.sink),
        .o_out   (res_ch.source)
    );

    wma_checker #(
        .MAX_TAPS (MAX_TAPS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (smp_ch),
        .i_out        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_zero_sums  (zero_sums)
    );

    // clock
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result receiver stalls at random
    always @(posedge clk) begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // one sample transaction, with a random gap in front
    task automatic send_sample(input t_sample value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= value;
        @(posedge clk);
        while (!smp_ch.ready) @(posedge clk);
        sent++;
    endtask

    // one register write transaction; valid is left high for a following write
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    // wait for every outstanding result, then let the block drain
    task automatic wait_idle();
        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input t_cfg_data taps, input t_cfg_data weights);
        wait_idle();
        write_reg(REG_TAP_COUNT, taps);
        write_reg(REG_TAP_WEIGHTS, weights);
        cfg_ch.valid <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        t_cfg_data taps;
        t_cfg_data weights;
        t_sample   value;
        int        phase;
        int        phase_len;
        int        random_start;
        int        k;

        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_TAP_COUNT;
        cfg_ch.data   <= '0;
        no_idle       <= 1'b0;
        rst_n         <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, history still partly zero
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh0000);

        // tap count of zero clamps to one, full-scale weights
        set_config(64'd0, {8{8'hFF}});
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);

        // tap count above the limit clamps to eight
        set_config(64'd15, {8{8'hFF}});
        repeat (3) send_sample(16'sh7FFF);
        repeat (3) send_sample(16'sh8000);

        // all weights zero
        set_config(64'd8, 64'd0);
        send_sample(16'sh1234);
        send_sample(16'sh8000);

        // only inactive taps weighted, then taps raised over the older samples
        set_config(64'd2, 64'hFFFF_FFFF_FFFF_0000);
        send_sample(16'sh7FFF);
        set_config(64'd8, 64'hFFFF_FFFF_FFFF_0000);
        send_sample(16'sh4000);

        // random phases of settings and samples
        phase        = 0;
        random_start = sent;
        while (sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(3))
                0: taps = $urandom_range(8, 1);
                1: taps = $urandom_range(15);
                2: taps = {$urandom, $urandom};
                default: taps = $urandom_range(1) ? 64'd1 : 64'd8;
            endcase
            case ($urandom_range(5))
                0: weights = {$urandom, $urandom};
                1: weights = {8{8'hFF}};
                2: weights = '0;
                3: begin
                    for (k = 0; k < WEIGHT_SLOTS; k++)
                        weights[WEIGHT_W*k +: WEIGHT_W] = $urandom_range(3);
                end
                4: begin
                    weights = '0;
                    weights[WEIGHT_W*$urandom_range(7) +: WEIGHT_W] = $urandom_range(255, 1);
                end
                default: weights = {$urandom, $urandom} & ~64'hFFFF_FFFF;
            endcase
            set_config(taps, weights);

            // one long phase with neither side stalling
            no_idle   <= (phase == CALM_PHASE);
            phase_len = (phase == CALM_PHASE) ? CALM_LEN : $urandom_range(80, 20);
            for (k = 0; k < phase_len; k++) begin
                case ($urandom_range(9))
                    0, 1: begin
                        case ($urandom_range(3))
                            0: value = 16'sh7FFF;
                            1: value = 16'sh8000;
                            2: value = '0;
                            default: value = 16'shFFFF;
                        endcase
                    end
                    2, 3: value = t_sample'($urandom_range(512)) - 16'sd256;
                    default: value = t_sample'($urandom);
                endcase
                send_sample(value);
            end
            phase++;
        end

        wait_idle();
        $display("Run covered %0d samples and %0d results over %0d register settings",
                 sent, results, settings + 1);
        $display("%0d results carried the zero weight sum flag", zero_sums);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
